/* design/pfa_pkg.sv */
// shared types, constants and codes for the page frame allocator
package pfa_pkg;

    localparam int PAGES     = 4096;
    localparam int MAX_RUN   = 256;
    localparam int REF_BITS  = 16;
    localparam int PAGE_W    = $clog2(PAGES);
    localparam int CNT_W     = $clog2(PAGES + 1);
    localparam int STATE_W   = 3;
    localparam int BND_RESET = 256;

    localparam logic [2:0] OP_SET   = 3'd0;
    localparam logic [2:0] OP_ALLOC = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_FREE  = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    localparam logic [2:0] ST_UNSET  = 3'd0;
    localparam logic [2:0] ST_USABLE = 3'd2;
    localparam logic [2:0] ST_SYSTEM = 3'd4;
    localparam logic [2:0] ST_ALLOC  = 3'd5;

    localparam logic [2:0] RS_OK      = 3'd0;
    localparam logic [2:0] RS_NOROOM  = 3'd1;
    localparam logic [2:0] RS_REGION  = 3'd2;
    localparam logic [2:0] RS_ILLEGAL = 3'd3;
    localparam logic [2:0] RS_NONE    = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [11:0] page;
        logic [8:0]  run_length;
        logic        want_dma;
        logic        at_fixed_page;
        logic [2:0]  new_state;
    } pfa_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] found_page;
        logic [2:0]  page_state;
        logic [15:0] page_refs;
        logic [12:0] usable_pages;
        logic [12:0] total_pages;
    } pfa_rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CHK_RD,
        S_CHK_EV,
        S_WR_RD,
        S_WR_EV,
        S_FIN_RD,
        S_FIN_EV,
        S_OUT
    } pfa_state_t;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic decode;
        logic chk_start;
        logic chk_step;
        logic wr_start;
        logic wr_step;
        logic fin_rd;
        logic fin_cap;
        logic out_load;
    } pfa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic dec_check;
        logic chk_fail;
        logic chk_last;
        logic chk_found;
        logic chk_none;
        logic wr_last;
    } pfa_sts_t;

    function automatic logic is_ram(input logic [2:0] s);
        return (s == ST_USABLE) || (s == ST_SYSTEM) || (s == ST_ALLOC);
    endfunction

endpackage

/* design/pfa_datapath.sv */
// page table memory, counters, scan and update pointers
module pfa_datapath
    import pfa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [12:0]         cfg_data,
    input  pfa_req_t            req,
    input  pfa_cmd_t            cmd,
    output pfa_sts_t            sts,
    output pfa_rsp_t            rsp
);

    logic [STATE_W+REF_BITS-1:0] mem [PAGES];
    logic [STATE_W+REF_BITS-1:0] rd_data_reg;

    pfa_req_t          req_reg;
    logic [12:0]       bnd_reg;
    logic [CNT_W-1:0]  usable_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [PAGE_W:0]   clr_reg;
    logic [PAGE_W:0]   ptr_reg;
    logic [PAGE_W:0]   base_reg;
    logic [PAGE_W:0]   hi_reg;
    logic [PAGE_W:0]   wptr_reg;
    logic [PAGE_W:0]   wend_reg;
    logic [2:0]        status_reg;
    logic [PAGE_W-1:0] found_reg;
    logic [2:0]        fst_reg;
    logic [15:0]       fref_reg;
    pfa_rsp_t          rsp_reg;

    logic [12:0]       bnd;
    logic [PAGE_W:0]   len_ext;
    logic [PAGE_W:0]   page_ext;
    logic [PAGE_W:0]   end_ext;
    logic              len_bad;
    logic [2:0]        rd_st;
    logic [REF_BITS-1:0] rd_ref;
    logic [PAGE_W:0]   ptr_next;
    logic              good;
    logic [PAGE_W-1:0] rd_addr;
    logic              we;
    logic [PAGE_W-1:0] wr_addr;
    logic [STATE_W+REF_BITS-1:0] wr_data;
    logic [2:0]        dec_status;
    logic              dec_check;
    logic [PAGE_W:0]   lo_c;
    logic [PAGE_W:0]   hi_c;

    assign bnd      = (bnd_reg < 13'(PAGES)) ? bnd_reg : 13'(PAGES);
    assign len_ext  = (PAGE_W+1)'(req_reg.run_length);
    assign page_ext = (PAGE_W+1)'(req_reg.page);
    assign end_ext  = page_ext + len_ext;
    assign len_bad  = (req_reg.run_length == '0) || (req_reg.run_length > 9'(MAX_RUN));
    assign rd_st    = rd_data_reg[STATE_W+REF_BITS-1:REF_BITS];
    assign rd_ref   = rd_data_reg[REF_BITS-1:0];

    // decode: checks that need no table reads
    always_comb
    begin
        dec_status = RS_OK;
        dec_check  = 1'b0;
        lo_c       = req_reg.want_dma ? '0 : (PAGE_W+1)'(bnd);
        hi_c       = req_reg.want_dma ? (PAGE_W+1)'(bnd) : (PAGE_W+1)'(PAGES);
        case (req_reg.opcode)
            OP_SET:
            begin
                if (req_reg.new_state > ST_ALLOC)
                    dec_status = RS_ILLEGAL;
            end
            OP_ALLOC:
            begin
                if (len_bad)
                    dec_status = RS_ILLEGAL;
                else if (req_reg.at_fixed_page)
                begin
                    lo_c = page_ext;
                    hi_c = end_ext;
                    if (((page_ext < (PAGE_W+1)'(bnd)) != req_reg.want_dma) ||
                        (end_ext > (req_reg.want_dma ? (PAGE_W+1)'(bnd)
                                                     : (PAGE_W+1)'(PAGES))))
                        dec_status = RS_REGION;
                    else if (usable_reg == '0)
                        dec_status = RS_NONE;
                    else
                        dec_check = 1'b1;
                end
                else if (usable_reg == '0)
                    dec_status = RS_NONE;
                else if (lo_c + len_ext > hi_c)
                    dec_status = RS_NOROOM;
                else
                    dec_check = 1'b1;
            end
            OP_ADD, OP_FREE:
            begin
                lo_c = page_ext;
                hi_c = end_ext;
                if (len_bad || end_ext > (PAGE_W+1)'(PAGES))
                    dec_status = RS_ILLEGAL;
                else
                    dec_check = 1'b1;
            end
            OP_QUERY: dec_status = RS_OK;
            default:  dec_status = RS_ILLEGAL;
        endcase
    end

    // check of the entry read last cycle at ptr_reg
    always_comb
    begin
        good = 1'b0;
        case (req_reg.opcode)
            OP_ALLOC: good = (rd_st == ST_USABLE);
            OP_ADD:   good = (rd_st == ST_ALLOC) && (rd_ref != {REF_BITS{1'b1}});
            OP_FREE:  good = (rd_st == ST_ALLOC) && (rd_ref != '0);
            default:  good = 1'b0;
        endcase
    end

    assign ptr_next = good ? ptr_reg + 1'b1 : ptr_reg + 1'b1;

    always_comb
    begin
        sts           = '0;
        sts.clr_done  = (clr_reg == (PAGE_W+1)'(PAGES - 1));
        sts.dec_check = dec_check;
        sts.chk_fail  = !good;
        // run complete when the next page would reach the run end
        sts.chk_found = good && (ptr_next == base_reg + len_ext);
        sts.chk_last  = sts.chk_found || (!good && !(req_reg.opcode == OP_ALLOC &&
                        !req_reg.at_fixed_page));
        sts.chk_none  = !good && (ptr_next + len_ext > hi_reg);
        sts.wr_last   = (wptr_reg + 1'b1 == wend_reg);
    end

    // read address
    always_comb
    begin
        rd_addr = ptr_reg[PAGE_W-1:0];
        if (cmd.load)
            rd_addr = req.page;
        else if (cmd.chk_start)
            rd_addr = base_reg[PAGE_W-1:0];
        else if (cmd.chk_step)
            rd_addr = ptr_next[PAGE_W-1:0];
        else if (cmd.wr_start || cmd.wr_step)
            rd_addr = cmd.wr_start ? wptr_reg[PAGE_W-1:0] : (wptr_reg[PAGE_W-1:0] + 1'b1);
        else if (cmd.fin_rd)
            rd_addr = req_reg.page;
    end

    // write data
    always_comb
    begin
        we      = 1'b0;
        wr_addr = wptr_reg[PAGE_W-1:0];
        wr_data = rd_data_reg;
        if (cmd.clr_step)
        begin
            we      = 1'b1;
            wr_addr = clr_reg[PAGE_W-1:0];
            wr_data = '0;
        end
        else if (cmd.decode && req_reg.opcode == OP_SET && dec_status == RS_OK)
        begin
            we      = 1'b1;
            wr_addr = req_reg.page;
            wr_data = {req_reg.new_state,
                       (req_reg.new_state == ST_ALLOC) ? REF_BITS'(1) : REF_BITS'(0)};
        end
        else if (cmd.wr_step)
        begin
            we = 1'b1;
            case (req_reg.opcode)
                OP_ALLOC: wr_data = {ST_ALLOC, REF_BITS'(1)};
                OP_ADD:   wr_data = {rd_st, rd_ref + 1'b1};
                OP_FREE:  wr_data = {(rd_ref == REF_BITS'(1)) ? ST_USABLE : rd_st,
                                     rd_ref - 1'b1};
                default:  wr_data = rd_data_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_reg    <= 13'(BND_RESET);
            usable_reg <= '0;
            total_reg  <= '0;
            clr_reg    <= '0;
            status_reg <= RS_OK;
        end
        else
        begin
            if (cfg_we)
                bnd_reg <= cfg_data;
            if (cmd.clr_step)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.decode)
            begin
                status_reg <= dec_status;
                if (req_reg.opcode == OP_SET && dec_status == RS_OK)
                begin
                    // old state arrives via the registered read issued at load
                    usable_reg <= usable_reg - CNT_W'(rd_st == ST_USABLE)
                                             + CNT_W'(req_reg.new_state == ST_USABLE);
                    total_reg  <= total_reg - CNT_W'(is_ram(rd_st))
                                            + CNT_W'(is_ram(req_reg.new_state));
                end
            end
            if (cmd.chk_step && !good && sts.chk_last)
                status_reg <= (req_reg.opcode == OP_ALLOC) ? RS_NOROOM : RS_ILLEGAL;
            if (cmd.chk_step && !good && !sts.chk_last && sts.chk_none)
                status_reg <= RS_NOROOM;
            if (cmd.wr_step)
            begin
                if (req_reg.opcode == OP_ALLOC)
                    usable_reg <= usable_reg - 1'b1;
                else if (req_reg.opcode == OP_FREE && rd_ref == REF_BITS'(1))
                    usable_reg <= usable_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.decode)
        begin
            base_reg  <= lo_c;
            ptr_reg   <= lo_c;
            hi_reg    <= hi_c;
            found_reg <= '0;
        end
        if (cmd.chk_step)
        begin
            if (good)
                ptr_reg <= ptr_next;
            else
            begin
                ptr_reg  <= ptr_next;
                base_reg <= ptr_next;
            end
            if (sts.chk_found)
            begin
                wptr_reg <= base_reg;
                wend_reg <= base_reg + len_ext;
                if (req_reg.opcode == OP_ALLOC)
                    found_reg <= base_reg[PAGE_W-1:0];
            end
        end
        if (cmd.wr_step)
            wptr_reg <= wptr_reg + 1'b1;
        if (cmd.fin_cap)
        begin
            fst_reg  <= rd_st;
            fref_reg <= rd_ref;
        end
        if (cmd.out_load)
        begin
            rsp_reg.status       <= status_reg;
            rsp_reg.found_page   <= found_reg;
            rsp_reg.page_state   <= fst_reg;
            rsp_reg.page_refs    <= fref_reg;
            rsp_reg.usable_pages <= usable_reg;
            rsp_reg.total_pages  <= total_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

/* design/pfa_ctrl.sv */
// sequencing state machine for clear, check, update and response
module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      out_busy,
    input  pfa_sts_t  sts,
    output pfa_cmd_t  cmd,
    output logic      idle,
    output logic      out_set
);

    pfa_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (sts.clr_done) state_next = S_IDLE;
            S_IDLE:   if (in_fire) state_next = S_DECODE;
            S_DECODE: state_next = sts.dec_check ? S_CHK_RD : S_FIN_RD;
            S_CHK_RD: state_next = S_CHK_EV;
            S_CHK_EV:
            begin
                if (sts.chk_found)
                    state_next = S_WR_RD;
                else if (sts.chk_last || (sts.chk_fail && sts.chk_none))
                    state_next = S_FIN_RD;
            end
            S_WR_RD:  state_next = S_WR_EV;
            S_WR_EV:  if (sts.wr_last) state_next = S_FIN_RD;
            S_FIN_RD: state_next = S_FIN_EV;
            S_FIN_EV: state_next = S_OUT;
            S_OUT:    if (!out_busy) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd     = '0;
        idle    = 1'b0;
        out_set = 1'b0;
        case (state_reg)
            S_CLEAR:  cmd.clr_step = 1'b1;
            S_IDLE:
            begin
                idle     = 1'b1;
                cmd.load = in_fire;
            end
            S_DECODE: cmd.decode = 1'b1;
            S_CHK_RD: cmd.chk_start = 1'b1;
            S_CHK_EV: cmd.chk_step = 1'b1;
            S_WR_RD:  cmd.wr_start = 1'b1;
            S_WR_EV:  cmd.wr_step = 1'b1;
            S_FIN_RD: cmd.fin_rd = 1'b1;
            S_FIN_EV: cmd.fin_cap = 1'b1;
            S_OUT:
            begin
                cmd.out_load = !out_busy;
                out_set      = !out_busy;
            end
            default:  cmd = '0;
        endcase
    end

endmodule

/* design/page_frame_allocator.sv */
// query, set_state and rejected requests skip the page checks: final page read, then response
// fixed alloc, add_ref and free check then update each of n pages; a failing check ends the walk
// a first-fit search checks one page of its region per cycle, then updates the n pages
// one request at a time, the next accepted only once the controller is idle again
// the response register frees the next request while held
// after reset a clearing pass zeroes all 4096 page table entries; no request accepted then
module page_frame_allocator
    import pfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  pfa_req_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output pfa_rsp_t    out_data,
    input  logic        cfg_we,
    input  logic [12:0] cfg_data
);

    pfa_cmd_t cmd;
    pfa_sts_t sts;
    logic     idle;
    logic     out_set;
    logic     out_valid_reg;
    logic     in_fire;

    assign in_stall = !idle;
    assign in_fire  = in_valid && idle;

    pfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (out_valid_reg && out_stall),
        .sts      (sts),
        .cmd      (cmd),
        .idle     (idle),
        .out_set  (out_set)
    );

    pfa_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .rsp      (out_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_set)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;

endmodule

/* design/pfa_checker.sv */
// port-level checks for the page frame allocator
module pfa_checker
    import pfa_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input pfa_rsp_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("response changed while stalled");

    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while one is in flight");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= RS_NONE)
        else $error("bad status code");

    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.usable_pages <= out_data.total_pages)
        else $error("usable count above total");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

/* dv/tb_page_frame_allocator.sv */
// self-checking testbench for the page frame allocator: directed and random requests
`timescale 1ns / 1ps

module tb_page_frame_allocator;
    import pfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int SETTLE_CYCLES  = 40;
    localparam logic [15:0] REF_MAX = 16'hFFFF;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    pfa_req_t    in_data;
    logic        out_valid;
    logic        out_stall;
    pfa_rsp_t    out_data;
    logic        cfg_we;
    logic [12:0] cfg_data;

    logic [2:0]  model_state [PAGES];
    logic [15:0] model_refs [PAGES];
    logic [12:0] model_usable;
    logic [12:0] model_total;
    logic [12:0] model_boundary;

    pfa_rsp_t    expected_rsps [$];
    int          mismatches;
    int          rsp_count;
    int          req_count;
    int          idle_cycles;
    bit          timed_out;
    bit          draining;

    page_frame_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit ram_code(input logic [2:0] s);
        return s == ST_USABLE || s == ST_SYSTEM || s == ST_ALLOC;
    endfunction

    function automatic bit run_free(input int start, input int len);
        for (int i = 0; i < len; i++)
            if (model_state[start + i] != ST_USABLE)
                return 0;
        return 1;
    endfunction

    task automatic take_pages(input int start, input int len);
        for (int i = 0; i < len; i++)
        begin
            model_state[start + i] = ST_ALLOC;
            model_refs[start + i] = 16'd1;
            model_usable--;
        end
    endtask

    task automatic allocate(input pfa_req_t r, output logic [2:0] st, output logic [11:0] fp);
        int bnd;
        int lo;
        int hi;
        int len;
        int b;
        int i;
        bnd = model_boundary < PAGES ? model_boundary : PAGES;
        lo = r.want_dma ? 0 : bnd;
        hi = r.want_dma ? bnd : PAGES;
        len = r.run_length;
        fp = '0;
        if (len == 0 || len > MAX_RUN)
        begin
            st = RS_ILLEGAL;
            return;
        end
        if (r.at_fixed_page)
        begin
            if ((int'(r.page) < bnd) != r.want_dma || int'(r.page) + len > hi)
                st = RS_REGION;
            else if (model_usable == 0)
                st = RS_NONE;
            else if (!run_free(r.page, len))
                st = RS_NOROOM;
            else
            begin
                take_pages(r.page, len);
                fp = r.page;
                st = RS_OK;
            end
            return;
        end
        if (model_usable == 0)
        begin
            st = RS_NONE;
            return;
        end
        b = lo;
        while (b + len <= hi)
        begin
            i = 0;
            while (i < len && model_state[b + i] == ST_USABLE)
                i++;
            if (i == len)
            begin
                take_pages(b, len);
                fp = 12'(b);
                st = RS_OK;
                return;
            end
            b += i + 1;
        end
        st = RS_NOROOM;
    endtask

    function automatic logic [2:0] change_refs(input pfa_req_t r, input bit raise);
        int len;
        int p;
        len = r.run_length;
        p = r.page;
        if (len == 0 || len > MAX_RUN || p + len > PAGES)
            return RS_ILLEGAL;
        for (int i = 0; i < len; i++)
        begin
            if (model_state[p + i] != ST_ALLOC)
                return RS_ILLEGAL;
            if (raise ? model_refs[p + i] == REF_MAX : model_refs[p + i] == 0)
                return RS_ILLEGAL;
        end
        for (int i = 0; i < len; i++)
        begin
            if (raise)
                model_refs[p + i]++;
            else
            begin
                model_refs[p + i]--;
                if (model_refs[p + i] == 0)
                begin
                    model_state[p + i] = ST_USABLE;
                    model_usable++;
                end
            end
        end
        return RS_OK;
    endfunction

    task automatic predict_response(input pfa_req_t r);
        pfa_rsp_t    e;
        logic [2:0]  st;
        logic [11:0] fp;
        logic [2:0]  old;
        fp = '0;
        case (r.opcode)
            OP_SET:
            begin
                if (r.new_state > ST_ALLOC)
                    st = RS_ILLEGAL;
                else
                begin
                    old = model_state[r.page];
                    if (old == ST_USABLE) model_usable--;
                    if (ram_code(old)) model_total--;
                    if (r.new_state == ST_USABLE) model_usable++;
                    if (ram_code(r.new_state)) model_total++;
                    model_state[r.page] = r.new_state;
                    model_refs[r.page] = (r.new_state == ST_ALLOC) ? 16'd1 : 16'd0;
                    st = RS_OK;
                end
            end
            OP_ALLOC: allocate(r, st, fp);
            OP_ADD:   st = change_refs(r, 1);
            OP_FREE:  st = change_refs(r, 0);
            OP_QUERY: st = RS_OK;
            default:  st = RS_ILLEGAL;
        endcase
        e.status       = st;
        e.found_page   = fp;
        e.page_state   = model_state[r.page];
        e.page_refs    = model_refs[r.page];
        e.usable_pages = model_usable;
        e.total_pages  = model_total;
        expected_rsps.push_back(e);
    endtask

    task automatic send_request(input pfa_req_t r);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        req_count++;
        predict_response(r);
    endtask

    task automatic send_op(input int op, input int page, input int len,
                           input int dma, input int fixed, input int ns);
        pfa_req_t r;
        r.opcode        = 3'(op);
        r.page          = 12'(page);
        r.run_length    = 9'(len);
        r.want_dma      = 1'(dma);
        r.at_fixed_page = 1'(fixed);
        r.new_state     = 3'(ns);
        send_request(r);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_rsps.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_boundary(input logic [12:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        model_boundary = value;
    endtask

    // response side stalls each response for a random wait, then takes it
    initial
    begin
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid)
            begin
                repeat ($urandom_range(0, 3)) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
                out_stall <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            rsp_count++;
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %p", out_data);
            end
            else
            begin
                if (out_data !== expected_rsps[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", expected_rsps[0], out_data);
                end
                void'(expected_rsps.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (draining || in_valid || expected_rsps.size() != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT + PAGES && !timed_out)
        begin
            timed_out = 1;
            $display("watchdog timeout");
            $display("** page_frame_allocator: FAILED **");
            $finish;
        end
    end

    task automatic test_boot_map();
        send_op(OP_QUERY, 0, 1, 0, 0, ST_UNSET);
        send_op(OP_ALLOC, 0, 1, 1, 0, ST_UNSET);
        for (int p = 0; p < 64; p += 4)
            send_op(OP_SET, p, 1, 0, 0, (p == 8) ? ST_SYSTEM : ST_USABLE);
        send_op(OP_SET, 4095, 1, 0, 0, ST_ALLOC);
        send_op(OP_SET, 5, 1, 0, 0, 3'd7);
        send_op(3'd6, 4095, 511, 1, 1, 3'd7);
        for (int p = 256; p < 400; p++)
        begin
            send_op(OP_SET, p, 1, 0, 0, ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 5))
                                                                     : ST_USABLE);
        end
        for (int p = 4000; p < 4095; p++)
            send_op(OP_SET, p, 1, 0, 0, ST_USABLE);
    endtask

    task automatic test_edge_cases();
        send_op(OP_ALLOC, 300, 0, 0, 1, ST_UNSET);
        send_op(OP_ALLOC, 300, 257, 0, 1, ST_UNSET);
        send_op(OP_ALLOC, 10, 2, 0, 1, ST_UNSET);
        send_op(OP_ALLOC, 250, 10, 1, 1, ST_UNSET);
        send_op(OP_ALLOC, 4000, 95, 0, 1, ST_UNSET);
        send_op(OP_ALLOC, 4090, 7, 0, 1, ST_UNSET);
        send_op(OP_ALLOC, 0, 1, 1, 0, ST_UNSET);
        send_op(OP_ALLOC, 0, 256, 0, 0, ST_UNSET);
        send_op(OP_ADD, 4095, 1, 0, 0, ST_UNSET);
        send_op(OP_ADD, 4095, 2, 0, 0, ST_UNSET);
        send_op(OP_FREE, 4095, 1, 0, 0, ST_UNSET);
        send_op(OP_FREE, 4095, 1, 0, 0, ST_UNSET);
        send_op(OP_FREE, 0, 1, 0, 0, ST_UNSET);
        send_op(OP_QUERY, 4095, 1, 1, 1, 3'd7);
    endtask

    task automatic test_random_traffic(input int count);
        int     op;
        int     len;
        int     page;
        for (int n = 0; n < count; n++)
        begin
            op   = $urandom_range(0, 99);
            len  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 8);
            page = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 1100);
            if (op < 10)
                send_op(OP_SET, page, 1, 0, 0, 3'($urandom_range(0, 7)));
            else if (op < 45)
                send_op(OP_ALLOC, page, len, $urandom_range(0, 1), $urandom_range(0, 2) == 0, 0);
            else if (op < 60)
                send_op(OP_ADD, page, len, $urandom, $urandom, $urandom);
            else if (op < 85)
                send_op(OP_FREE, page, len, $urandom, $urandom, $urandom);
            else if (op < 97)
                send_op(OP_QUERY, page, $urandom, $urandom, $urandom, $urandom);
            else
                send_op(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic test_boundary_settings();
        write_boundary(13'd1);
        test_random_traffic(50);
        write_boundary(13'd4096);
        test_random_traffic(40);
        write_boundary(13'd8191);
        test_random_traffic(30);
        write_boundary(13'd700);
        test_random_traffic(70);
        write_boundary(13'd256);
        test_random_traffic(70);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        mismatches = 0;
        rsp_count  = 0;
        req_count  = 0;
        timed_out  = 0;
        draining   = 0;
        for (int p = 0; p < PAGES; p++)
        begin
            model_state[p] = ST_UNSET;
            model_refs[p]  = '0;
        end
        model_usable   = '0;
        model_total    = '0;
        model_boundary = 13'(BND_RESET);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_cases();
        test_boot_map();
        test_edge_cases();
        test_boundary_settings();
        draining = 1;
        wait_idle();
        $display("covered %0d requests and %0d responses", req_count, rsp_count);
        $display("boundary settings 1, 256, 700, 4096 and 8191; %0d mismatches", mismatches);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("** page_frame_allocator: PASSED **");
        else
            $display("** page_frame_allocator: FAILED **");
        $finish;
    end

endmodule
